[design/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg: shared types and codes of the sorted keyed table
// Entry layout, item and status codes, cell control and the sequencer states.
// ----------------------------------------------------------------------------
package skt_pkg;

  typedef struct packed {
    logic [15:0] id;
    logic [1:0]  category;
    logic [10:0] age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Item kinds.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_APPLY
  } state_t;

  // Update strobes broadcast to every cell of the chain.
  typedef struct packed {
    logic ins_go;
    logic del_go;
  } cell_cmd_t;

endpackage

[design/skt_if.sv]
// ----------------------------------------------------------------------------
// skt_if: item and result channels of the sorted keyed table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface skt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] entry_id;
  logic [1:0]  entry_category;
  logic [10:0] entry_age;
  logic [4:0]  read_index;

  modport source (output valid, output kind, output entry_id, output entry_category,
                  output entry_age, output read_index, input ready);
  modport sink   (input valid, input kind, input entry_id, input entry_category,
                  input entry_age, input read_index, output ready);
endinterface

interface skt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [5:0]  entry_count;
  logic [15:0] out_id;
  logic [1:0]  out_category;
  logic [10:0] out_age;

  modport source (output valid, output status, output entry_count, output out_id,
                  output out_category, output out_age, input ready);
  modport sink   (input valid, input status, input entry_count, input out_id,
                  input out_category, input out_age, output ready);
endinterface

[design/skt_cell.sv]
// ----------------------------------------------------------------------------
// skt_cell: one position of the sorted table
// Holds one entry, compares it with an arriving key and shifts with its
// neighbors when an entry is inserted ahead of it or removed at or before it.
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic               clk,
  input  logic               cap,
  input  logic               occupied,
  input  skt_pkg::entry_t    cmp_key,
  input  skt_pkg::entry_t    new_entry,
  input  skt_pkg::entry_t    left_entry,
  input  skt_pkg::entry_t    right_entry,
  input  logic               prev_mark,
  input  logic               seen,
  input  skt_pkg::cell_cmd_t cmd,
  output skt_pkg::entry_t    entry_q,
  output logic               mark_q,
  output logic               match_q
);
  import skt_pkg::*;

  entry_t entry_r, entry_nxt;
  logic   mark_r, match_r;
  logic   mark_nxt, match_nxt;

  // The new key goes at or ahead of this position when the held entry does
  // not come before it; empty positions always count as behind the key.
  always_comb begin
    mark_nxt  = !occupied
             || (entry_r.category > cmp_key.category)
             || ((entry_r.category == cmp_key.category) && (cmp_key.age >= entry_r.age));
    match_nxt = occupied && (entry_r.id == cmp_key.id);
  end

  always_comb begin
    entry_nxt = entry_r;
    if (cmd.ins_go && mark_r) begin
      entry_nxt = prev_mark ? left_entry : new_entry;
    end else if (cmd.del_go && seen) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (cap) begin
      mark_r  <= mark_nxt;
      match_r <= match_nxt;
    end
  end

  assign entry_q = entry_r;
  assign mark_q  = mark_r;
  assign match_q = match_r;

endmodule

[design/sorted_keyed_table_unit.sv]
// ----------------------------------------------------------------------------
// sorted_keyed_table_unit: bounded table kept sorted by category and age
// Top level: item sequencer, result register and the chain of table cells.
// ----------------------------------------------------------------------------
// Usage:
//   Items arrive on in_ch (insert, delete by id, read at index) and every item
//   gives exactly one result on out_ch. Entries are kept ordered by category
//   ascending and, within a category, by age descending; a new entry goes
//   ahead of existing entries of equal age.
//   Each entry lives in its own cell. On the transfer of an item every cell
//   compares its entry with the item's key and stores the outcome. In the
//   update state, once the result can be registered, all cells shift
//   together: up by one from the insert position, or down by one from the
//   first matching id. The result register is written from the update
//   state, which waits while an earlier result is still waiting on out_ch.
//   Each item has a compare step and an update step; a new item is taken
//   only after the update of the last one, which waits on the result register.
//   The result register decouples out_ch, so a finished result may wait
//   while the next item is accepted. While out_ch stalls with a result held,
//   the pending update waits and in_ch stays not ready.
//   Reset clears the entry count and the handshake state; cell contents are
//   not cleared and are only visible below the entry count.
// ----------------------------------------------------------------------------
module sorted_keyed_table_unit #(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst_n,
  skt_in_if.sink    in_ch,
  skt_out_if.source out_ch
);
  import skt_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

  state_t state_r, state_nxt;

  // Item held for the update cycle.
  logic [1:0]       kind_r;
  entry_t           new_r;
  logic [4:0]       idx_r;

  logic [CNT_W-1:0] count_r, count_nxt;

  // Result register.
  logic             out_valid_r;
  logic [1:0]       status_r, status_nxt;
  logic [CNT_W-1:0] cnt_out_r;
  entry_t           data_r, data_nxt;

  logic             in_accept;
  logic             can_emit;
  logic             apply_fire;
  logic             full;
  logic             found;
  logic             idx_ok;
  cell_cmd_t        cmd;
  entry_t           cmp_key;
  entry_t           rd_entry;

  entry_t           entry_q [CAPACITY];
  logic [CAPACITY-1:0] mark_q;
  logic [CAPACITY-1:0] match_q;
  logic [CAPACITY-1:0] seen;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] rd_hit;

  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign can_emit = !out_valid_r || out_ch.ready;

  assign cmp_key.id       = in_ch.entry_id;
  assign cmp_key.category = in_ch.entry_category;
  assign cmp_key.age      = in_ch.entry_age;

  // Sequencer: a compare on the transfer, then the update, held until can_emit.
  always_comb begin
    state_nxt  = state_r;
    apply_fire = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (can_emit) begin
          apply_fire = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      kind_r <= in_ch.kind;
      new_r  <= cmp_key;
      idx_r  <= in_ch.read_index;
    end
  end

  // The chain of cells, with occupancy derived from the entry count.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam logic [CNT_W-1:0] POS = CNT_W'(g);
    entry_t left_e, right_e;
    logic   prev_m;

    assign occ[g]    = (count_r > POS);
    assign rd_hit[g] = (CMP_W'(idx_r) == CMP_W'(g));

    if (g == 0) begin : g_first
      assign left_e = new_r;
      assign prev_m = 1'b0;
    end else begin : g_inner
      assign left_e = entry_q[g-1];
      assign prev_m = mark_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign right_e = entry_q[g];
    end else begin : g_mid
      assign right_e = entry_q[g+1];
    end

    skt_cell u_cell (
      .clk         (clk),
      .cap         (in_accept),
      .occupied    (occ[g]),
      .cmp_key     (cmp_key),
      .new_entry   (new_r),
      .left_entry  (left_e),
      .right_entry (right_e),
      .prev_mark   (prev_m),
      .seen        (seen[g]),
      .cmd         (cmd),
      .entry_q     (entry_q[g]),
      .mark_q      (mark_q[g]),
      .match_q     (match_q[g])
    );
  end

  // A cell shifts down on delete when it or any cell before it matched.
  always_comb begin
    seen = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      for (int j = 0; j <= i; j++) begin
        seen[i] = seen[i] | match_q[j];
      end
    end
  end

  assign found = seen[CAPACITY-1];
  assign full  = (count_r == CNT_W'(CAPACITY));
  assign idx_ok = (CMP_W'(idx_r) < CMP_W'(count_r));

  always_comb begin
    rd_entry = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_entry = rd_entry | (entry_q[i] & {ENTRY_W{rd_hit[i]}});
    end
  end

  // Outcome of the held item.
  always_comb begin
    status_nxt = STATUS_OK;
    count_nxt  = count_r;
    data_nxt   = '0;
    cmd        = '0;
    case (kind_r)
      KIND_INSERT: begin
        if (full) begin
          status_nxt = STATUS_FULL;
        end else begin
          cmd.ins_go = apply_fire;
          count_nxt  = count_r + CNT_W'(1);
        end
      end
      KIND_DELETE: begin
        if (found) begin
          cmd.del_go = apply_fire;
          count_nxt  = count_r - CNT_W'(1);
        end else begin
          status_nxt = STATUS_NOT_FOUND;
        end
      end
      KIND_READ: begin
        if (idx_ok) begin
          data_nxt = rd_entry;
        end else begin
          status_nxt = STATUS_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (apply_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_fire) begin
      status_r  <= status_nxt;
      cnt_out_r <= count_nxt;
      data_r    <= data_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.entry_count  = 6'(cnt_out_r);
  assign out_ch.out_id       = data_r.id;
  assign out_ch.out_category = data_r.category;
  assign out_ch.out_age      = data_r.age;

  // The entry count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Every transfer is followed by an update cycle.
  a_accept_apply: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_APPLY))
    else $error("no update cycle after transfer");

  // A completed insert grows the table by one.
  a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_go |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the table");

  // A completed delete shrinks the table by one.
  a_delete_shrink: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.del_go |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("delete did not shrink the table");

  // A full status is only reported while the table is full.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (status_r == STATUS_FULL)) |-> full)
    else $error("full status with room left");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the sorted keyed table
// A clocked driver feeds items from a queue and a clocked monitor checks every
// result against an in-bench copy of the sorted table, under varying stalls.
// ----------------------------------------------------------------------------
module tb;
  import skt_pkg::*;

  localparam int CAPACITY      = 32;
  localparam int HALF_PERIOD   = 6;
  localparam int TIMEOUT_NS    = 400_000 * 2 * HALF_PERIOD;
  localparam int TAIL_CYCLES   = 16;
  localparam int HOLD_CYCLES   = 300;
  localparam int ID_POOL_DEPTH = 48;

  // The fourth item code is not used by the table; it must leave it untouched.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] id;
    logic [1:0]  category;
    logic [10:0] age;
    logic [4:0]  index;
  } table_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  entry_count;
    logic [15:0] id;
    logic [1:0]  category;
    logic [10:0] age;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  skt_in_if  in_ch ();
  skt_out_if out_ch ();

  sorted_keyed_table_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  // Items waiting to be offered, and results predicted but not yet seen.
  table_item_t   item_q[$];
  table_result_t expected_q[$];

  // Shadow copy of the table that the predictor keeps in step with the block.
  entry_t        shadow_entries[CAPACITY];
  int            shadow_count = 0;

  // Ids the stimulus has inserted, so that most deletes hit a live entry.
  logic [15:0]   live_ids[$];

  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_left = 0;
  int            mismatches = 0;
  bit            offer_live = 1'b0;
  table_item_t   next_item;
  table_item_t   taken_item;
  table_result_t oldest;

  // Applies one item to the shadow table and returns the result it must give.
  // Inserts go ahead of the first entry with a larger category, or with the
  // same category and an age not above the new one, so ties land in front.
  function automatic table_result_t apply_item(table_item_t it);
    table_result_t res;
    int            pos;
    res = '0;
    case (it.kind)
      KIND_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          res.status = STATUS_FULL;
        end else begin
          pos = shadow_count;
          for (int i = shadow_count - 1; i >= 0; i--) begin
            if (shadow_entries[i].category > it.category ||
                (shadow_entries[i].category == it.category &&
                 it.age >= shadow_entries[i].age)) begin
              pos = i;
            end
          end
          for (int i = shadow_count; i > pos; i--) begin
            shadow_entries[i] = shadow_entries[i - 1];
          end
          shadow_entries[pos].id       = it.id;
          shadow_entries[pos].category = it.category;
          shadow_entries[pos].age      = it.age;
          shadow_count++;
        end
      end
      KIND_DELETE: begin
        // Only the first entry with a matching id goes; duplicates stay.
        pos = -1;
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_entries[i].id == it.id) begin
            pos = i;
          end
        end
        if (pos < 0) begin
          res.status = STATUS_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < shadow_count; i++) begin
            shadow_entries[i] = shadow_entries[i + 1];
          end
          shadow_count--;
        end
      end
      KIND_READ: begin
        if (int'(it.index) < shadow_count) begin
          res.id       = shadow_entries[it.index].id;
          res.category = shadow_entries[it.index].category;
          res.age      = shadow_entries[it.index].age;
        end else begin
          res.status = STATUS_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = shadow_count[5:0];
    return res;
  endfunction

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  task automatic push_item(logic [1:0] kind, logic [15:0] id, logic [1:0] category,
                           logic [10:0] age, logic [4:0] index);
    item_q.push_back('{kind: kind, id: id, category: category, age: age, index: index});
  endtask

  // Builds one random item. Ages cluster on a few values now and then so that
  // equal keys meet; a small id span makes duplicate ids common.
  function automatic table_item_t random_item(int ins_pct, int del_pct, int id_span);
    table_item_t it;
    int          roll;
    int          pick;
    it.kind     = KIND_READ;
    it.id       = (id_span == 0) ? 16'($urandom) : 16'($urandom_range(id_span - 1));
    it.category = 2'($urandom_range(3));
    it.age      = 11'($urandom_range(2047));
    it.index    = 5'($urandom_range(31));
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(3))
        0: it.age = 11'd0;
        1: it.age = 11'd2047;
        2: it.age = 11'd100;
        default: it.age = 11'd1000;
      endcase
    end
    roll = $urandom_range(99);
    if (roll < 3) begin
      it.kind = KIND_UNUSED;
    end else if (roll < 3 + ins_pct) begin
      it.kind = KIND_INSERT;
      if (live_ids.size() >= ID_POOL_DEPTH) begin
        void'(live_ids.pop_front());
      end
      live_ids.push_back(it.id);
    end else if (roll < 3 + ins_pct + del_pct) begin
      it.kind = KIND_DELETE;
      if (live_ids.size() != 0 && $urandom_range(4) != 0) begin
        pick  = $urandom_range(live_ids.size() - 1);
        it.id = live_ids[pick];
        live_ids.delete(pick);
      end
    end
    return it;
  endfunction

  // Waits until every queued item has been taken and every result checked.
  task automatic wait_drained();
    while (item_q.size() != 0 || offer_live || expected_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic run_phase(int send_idle, int recv_idle, int n, int ins_pct,
                           int del_pct, int id_span);
    send_idle_pct = send_idle;
    recv_idle_pct = recv_idle;
    repeat (n) item_q.push_back(random_item(ins_pct, del_pct, id_span));
    wait_drained();
  endtask

  // Every input starts at a known value; the clocked drivers take over later.
  initial begin
    in_ch.valid          = 1'b0;
    in_ch.kind           = KIND_INSERT;
    in_ch.entry_id       = '0;
    in_ch.entry_category = '0;
    in_ch.entry_age      = '0;
    in_ch.read_index     = '0;
    out_ch.ready         = 1'b0;
  end

  // Item driver. A new item is put up at the falling edge only once the last
  // one has been taken, so valid never drops while an item is on offer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!offer_live) begin
      if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = item_q.pop_front();
        in_ch.kind           <= next_item.kind;
        in_ch.entry_id       <= next_item.id;
        in_ch.entry_category <= next_item.category;
        in_ch.entry_age      <= next_item.age;
        in_ch.read_index     <= next_item.index;
        in_ch.valid          <= 1'b1;
        offer_live = 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver. A long hold-off, when one is requested, is counted down
  // here and overrides the random stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Each item transfer advances the shadow table and queues the result due.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      taken_item.kind     = in_ch.kind;
      taken_item.id       = in_ch.entry_id;
      taken_item.category = in_ch.entry_category;
      taken_item.age      = in_ch.entry_age;
      taken_item.index    = in_ch.read_index;
      expected_q.push_back(apply_item(taken_item));
      offer_live = 1'b0;
    end
  end

  // Each result transfer is matched against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $error("result with no item outstanding: status %0d count %0d",
               out_ch.status, out_ch.entry_count);
        mismatches++;
      end else begin
        oldest = expected_q.pop_front();
        check_field("status", 16'(oldest.status), 16'(out_ch.status));
        check_field("entry_count", 16'(oldest.entry_count), 16'(out_ch.entry_count));
        check_field("out_id", oldest.id, out_ch.out_id);
        check_field("out_category", 16'(oldest.category), 16'(out_ch.out_category));
        check_field("out_age", 16'(oldest.age), 16'(out_ch.out_age));
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: the empty table, the unused code, ties on equal keys,
    // category three, reads past the end and deletes of duplicate and
    // unknown ids.
    push_item(KIND_READ,   16'd0,      2'd0, 11'd0,    5'd0);
    push_item(KIND_DELETE, 16'd0,      2'd0, 11'd0,    5'd0);
    push_item(KIND_UNUSED, 16'hFFFF,   2'd3, 11'd2047, 5'd31);
    push_item(KIND_INSERT, 16'hFFFF,   2'd3, 11'd2047, 5'd0);
    push_item(KIND_INSERT, 16'd0,      2'd0, 11'd0,    5'd0);
    push_item(KIND_INSERT, 16'd1,      2'd2, 11'd100,  5'd0);
    push_item(KIND_INSERT, 16'd2,      2'd2, 11'd100,  5'd0);
    push_item(KIND_INSERT, 16'd3,      2'd1, 11'd2047, 5'd0);
    push_item(KIND_INSERT, 16'd4,      2'd0, 11'd2047, 5'd0);
    for (int i = 0; i < 6; i++) begin
      push_item(KIND_READ, 16'd0, 2'd0, 11'd0, 5'(i));
    end
    push_item(KIND_READ,   16'd0,      2'd0, 11'd0,    5'd6);
    push_item(KIND_READ,   16'd0,      2'd0, 11'd0,    5'd31);
    push_item(KIND_DELETE, 16'd2,      2'd0, 11'd0,    5'd0);
    push_item(KIND_DELETE, 16'hFFFF,   2'd0, 11'd0,    5'd0);
    push_item(KIND_DELETE, 16'h1234,   2'd0, 11'd0,    5'd0);
    push_item(KIND_INSERT, 16'd5,      2'd0, 11'd0,    5'd0);
    push_item(KIND_INSERT, 16'd4,      2'd3, 11'd5,    5'd0);
    push_item(KIND_DELETE, 16'd4,      2'd0, 11'd0,    5'd0);
    push_item(KIND_READ,   16'd0,      2'd0, 11'd0,    5'd0);
    push_item(KIND_READ,   16'd0,      2'd0, 11'd0,    5'd1);
    push_item(KIND_UNUSED, 16'd0,      2'd0, 11'd0,    5'd0);
    wait_drained();

    // Random part. Insert-heavy phases drive the table full so that inserts
    // get refused; delete-heavy phases drain it again.
    run_phase(0,  0,  120, 80, 10, 0);
    run_phase(58, 0,  120, 40, 30, 8);
    run_phase(0,  58, 120, 15, 70, 0);
    run_phase(17, 17, 120, 40, 30, 8);

    // Back-pressure: the receiver holds off while the sender keeps offering,
    // so the result register fills and the input stalls.
    hold_left = HOLD_CYCLES;
    run_phase(0,  0,  100, 80, 10, 0);

    run_phase(0,  0,  80,  40, 30, 0);
    run_phase(17, 17, 90,  20, 60, 8);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
